// ----- src/ep0r_pkg.sv -----
// Shared types, codes, microcode and the configuration descriptor table for the endpoint zero responder.
`timescale 1ns / 1ps

package ep0r_pkg;

    // Input word: one decoded setup request or one IN token
    typedef struct packed {
        logic        action;
        logic [7:0]  request_type;
        logic [7:0]  request_code;
        logic [15:0] request_value;
        logic [15:0] request_length;
    } t_in;

    // Output word: one result of a run
    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data_byte;
        logic [7:0] device_address;
        logic       last;
    } t_out;

    typedef enum logic [2:0] {
        KIND_DATA       = 3'd0,
        KIND_EMPTY      = 3'd1,
        KIND_STALL      = 3'd2,
        KIND_ADDR       = 3'd3,
        KIND_CONFIGURED = 3'd4
    } t_kind;

    // Configuration register indexes
    localparam logic [1:0] REG_PACKET  = 2'd0;
    localparam logic [1:0] REG_VENDOR  = 2'd1;
    localparam logic [1:0] REG_PRODUCT = 2'd2;

    localparam logic [6:0]  RST_PACKET  = 7'd8;
    localparam logic [15:0] RST_VENDOR  = 16'hA598;
    localparam logic [15:0] RST_PRODUCT = 16'h0002;

    localparam logic       ACT_SETUP = 1'b0;
    localparam logic       ACT_IN    = 1'b1;

    localparam logic [7:0] REQ_TYPE_IN    = 8'h80;
    localparam logic [7:0] REQ_TYPE_OUT   = 8'h00;
    localparam logic [7:0] REQ_GET_DESC   = 8'd6;
    localparam logic [7:0] REQ_SET_ADDR   = 8'd5;
    localparam logic [7:0] REQ_SET_CONFIG = 8'd9;

    localparam logic [7:0] DESC_DEVICE    = 8'd1;
    localparam logic [7:0] DESC_CONFIG    = 8'd2;
    localparam logic [7:0] DESC_QUALIFIER = 8'd6;

    localparam logic [5:0] DEVICE_DESC_BYTES  = 6'd18;
    localparam logic [5:0] CONFIG_SHORT_BYTES = 6'd9;
    localparam logic [5:0] CFG_TOTAL_SLOT     = 6'd2;

    // Microprogram steps
    typedef enum logic [3:0] {
        S_IDLE  = 4'd0,
        S_DEV   = 4'd1,
        S_CFG   = 4'd2,
        S_QUAL  = 4'd3,
        S_ADDR0 = 4'd4,
        S_ADDR1 = 4'd5,
        S_CONF0 = 4'd6,
        S_CONF1 = 4'd7,
        S_CHUNK = 4'd8,
        S_BYTE  = 4'd9,
        S_EMPTY = 4'd10
    } t_step;

    typedef enum logic [1:0] {
        JC_NONE     = 2'd0,
        JC_DISPATCH = 2'd1,
        JC_ZERO     = 2'd2,
        JC_LAST     = 2'd3
    } t_jcond;

    typedef enum logic [1:0] {
        LS_ZERO = 2'd0,
        LS_ONE  = 2'd1,
        LS_CNT  = 2'd2
    } t_lastsel;

    typedef enum logic [2:0] {
        XOP_NONE     = 3'd0,
        XOP_LOAD_DEV = 3'd1,
        XOP_LOAD_CFG = 3'd2,
        XOP_CLEAR    = 3'd3,
        XOP_ADVANCE  = 3'd4
    } t_xop;

    typedef struct packed {
        logic     wait_in;
        logic     emit;
        t_kind    kind;
        t_lastsel lsel;
        t_xop     xop;
        logic     ld_addr;
        logic     ld_cnt;
        t_jcond   jc;
        t_step    jt;
        t_step    nt;
    } t_uword;

    // Status from datapath to sequencer
    typedef struct packed {
        logic  in_fire;
        logic  disp_ok;
        t_step disp;
        logic  n_zero;
        logic  cnt_last;
        logic  out_free;
    } t_stat;

    function automatic t_uword uw(input logic wait_in, input logic emit, input t_kind kind,
                                  input t_lastsel lsel, input t_xop xop, input logic ld_addr,
                                  input logic ld_cnt, input t_jcond jc, input t_step jt,
                                  input t_step nt);
        t_uword w;
        w.wait_in = wait_in;
        w.emit    = emit;
        w.kind    = kind;
        w.lsel    = lsel;
        w.xop     = xop;
        w.ld_addr = ld_addr;
        w.ld_cnt  = ld_cnt;
        w.jc      = jc;
        w.jt      = jt;
        w.nt      = nt;
        return w;
    endfunction

    // Control store
    function automatic t_uword ucode(input t_step s);
        t_uword w;
        case (s)
            S_IDLE:  w = uw(1'b1, 1'b0, KIND_DATA, LS_ZERO, XOP_NONE, 1'b0, 1'b0,
                            JC_DISPATCH, S_IDLE, S_IDLE);
            S_DEV:   w = uw(1'b0, 1'b0, KIND_DATA, LS_ZERO, XOP_LOAD_DEV, 1'b0, 1'b0,
                            JC_NONE, S_CHUNK, S_CHUNK);
            S_CFG:   w = uw(1'b0, 1'b0, KIND_DATA, LS_ZERO, XOP_LOAD_CFG, 1'b0, 1'b0,
                            JC_NONE, S_CHUNK, S_CHUNK);
            S_QUAL:  w = uw(1'b0, 1'b1, KIND_STALL, LS_ONE, XOP_NONE, 1'b0, 1'b0,
                            JC_NONE, S_IDLE, S_IDLE);
            S_ADDR0: w = uw(1'b0, 1'b1, KIND_EMPTY, LS_ZERO, XOP_CLEAR, 1'b1, 1'b0,
                            JC_NONE, S_ADDR1, S_ADDR1);
            S_ADDR1: w = uw(1'b0, 1'b1, KIND_ADDR, LS_ONE, XOP_NONE, 1'b0, 1'b0,
                            JC_NONE, S_IDLE, S_IDLE);
            S_CONF0: w = uw(1'b0, 1'b1, KIND_CONFIGURED, LS_ZERO, XOP_CLEAR, 1'b0, 1'b0,
                            JC_NONE, S_CONF1, S_CONF1);
            S_CONF1: w = uw(1'b0, 1'b1, KIND_EMPTY, LS_ONE, XOP_NONE, 1'b0, 1'b0,
                            JC_NONE, S_IDLE, S_IDLE);
            S_CHUNK: w = uw(1'b0, 1'b0, KIND_DATA, LS_ZERO, XOP_NONE, 1'b0, 1'b1,
                            JC_ZERO, S_EMPTY, S_BYTE);
            S_BYTE:  w = uw(1'b0, 1'b1, KIND_DATA, LS_CNT, XOP_ADVANCE, 1'b0, 1'b0,
                            JC_LAST, S_IDLE, S_BYTE);
            S_EMPTY: w = uw(1'b0, 1'b1, KIND_EMPTY, LS_ONE, XOP_NONE, 1'b0, 1'b0,
                            JC_NONE, S_IDLE, S_IDLE);
            default: w = uw(1'b0, 1'b0, KIND_DATA, LS_ZERO, XOP_NONE, 1'b0, 1'b0,
                            JC_NONE, S_IDLE, S_IDLE);
        endcase
        return w;
    endfunction

    // Configuration descriptor; the total length slot is patched by the datapath
    function automatic logic [7:0] cfg_rom(input logic [5:0] idx);
        logic [7:0] b;
        case (idx)
            6'd0:  b = 8'h09;
            6'd1:  b = 8'h02;
            6'd4:  b = 8'h01;
            6'd5:  b = 8'h01;
            6'd7:  b = 8'h80;
            6'd8:  b = 8'd250;
            6'd9:  b = 8'h09;
            6'd10: b = 8'h04;
            6'd13: b = 8'h02;
            6'd14: b = 8'hff;
            6'd16: b = 8'hff;
            6'd18: b = 8'h07;
            6'd19: b = 8'h05;
            6'd20: b = 8'h82;
            6'd21: b = 8'h02;
            6'd22: b = 8'h40;
            6'd24: b = 8'h01;
            6'd25: b = 8'h07;
            6'd26: b = 8'h05;
            6'd27: b = 8'h02;
            6'd28: b = 8'h02;
            6'd29: b = 8'h40;
            6'd31: b = 8'h01;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ----- src/ep0r_seq.sv -----
// Microprogram sequencer: step counter, control store lookup and branch logic.
`timescale 1ns / 1ps

module ep0r_seq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ep0r_pkg::t_stat  i_stat,
    output ep0r_pkg::t_uword o_uw,
    output logic             o_go
);

    ep0r_pkg::t_step  r_step;
    ep0r_pkg::t_step  n_step;
    ep0r_pkg::t_uword w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ep0r_pkg::S_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    always_comb begin
        w      = ep0r_pkg::ucode(r_step);
        // an emitting step waits for room in the output register
        o_go   = w.emit ? i_stat.out_free : 1'b1;
        n_step = r_step;
        case (w.jc)
            ep0r_pkg::JC_DISPATCH: begin
                if (i_stat.in_fire && i_stat.disp_ok) begin
                    n_step = i_stat.disp;
                end
            end
            ep0r_pkg::JC_ZERO: begin
                n_step = i_stat.n_zero ? w.jt : w.nt;
            end
            ep0r_pkg::JC_LAST: begin
                if (o_go) begin
                    n_step = i_stat.cnt_last ? w.jt : w.nt;
                end
            end
            default: begin
                if (o_go) begin
                    n_step = w.nt;
                end
            end
        endcase
        o_uw = w;
    end

endmodule

// ----- src/ep0r_dp.sv -----
// Datapath: request decode, transfer state, descriptor bytes and output register.
`timescale 1ns / 1ps

module ep0r_dp #(
    parameter int MAX_PACKET         = 64,
    parameter int CONFIG_TOTAL_BYTES = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  ep0r_pkg::t_in    i_in,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output ep0r_pkg::t_out   o_out,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_idx,
    input  logic [15:0]      i_cfg_data,
    input  ep0r_pkg::t_uword i_uw,
    input  logic             i_go,
    output ep0r_pkg::t_stat  o_stat
);

    localparam logic [6:0] MaxPkt   = 7'(MAX_PACKET);
    localparam logic [5:0] CfgTotal = 6'(CONFIG_TOTAL_BYTES);

    logic [6:0]  r_pkt;
    logic [15:0] r_vid;
    logic [15:0] r_pid;

    logic        r_src_cfg;
    logic [5:0]  r_offset;
    logic [5:0]  r_remain;
    logic [7:0]  r_addr;
    logic [5:0]  r_cnt;
    logic [7:0]  r_value_lo;
    logic        r_len_full;

    logic        r_out_valid;
    ep0r_pkg::t_out r_out;

    logic        in_fire;
    logic [6:0]  pkt_eff;
    logic [5:0]  n_chunk;
    logic [7:0]  dev_byte;
    logic [7:0]  rom_byte;
    logic        out_free;
    logic        cur_last;
    logic [7:0]  desc_type;

    assign o_in_ready  = i_uw.wait_in;
    assign in_fire     = i_in_valid && i_uw.wait_in;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign desc_type   = i_in.request_value[15:8];

    // Request decode into a dispatch target
    always_comb begin
        o_stat.in_fire  = in_fire;
        o_stat.disp_ok  = 1'b0;
        o_stat.disp     = ep0r_pkg::S_IDLE;
        o_stat.out_free = out_free;
        o_stat.cnt_last = (r_cnt == 6'd1);
        o_stat.n_zero   = (n_chunk == 6'd0);
        if (i_in.action == ep0r_pkg::ACT_IN) begin
            o_stat.disp_ok = (r_addr != 8'd0);
            o_stat.disp    = ep0r_pkg::S_CHUNK;
        end else if (i_in.request_type == ep0r_pkg::REQ_TYPE_IN
                     && i_in.request_code == ep0r_pkg::REQ_GET_DESC) begin
            case (desc_type)
                ep0r_pkg::DESC_DEVICE: begin
                    o_stat.disp_ok = 1'b1;
                    o_stat.disp    = ep0r_pkg::S_DEV;
                end
                ep0r_pkg::DESC_CONFIG: begin
                    o_stat.disp_ok = 1'b1;
                    o_stat.disp    = ep0r_pkg::S_CFG;
                end
                ep0r_pkg::DESC_QUALIFIER: begin
                    o_stat.disp_ok = 1'b1;
                    o_stat.disp    = ep0r_pkg::S_QUAL;
                end
                default: begin
                    o_stat.disp_ok = 1'b0;
                end
            endcase
        end else if (i_in.request_type == ep0r_pkg::REQ_TYPE_OUT
                     && i_in.request_code == ep0r_pkg::REQ_SET_ADDR) begin
            o_stat.disp_ok = 1'b1;
            o_stat.disp    = ep0r_pkg::S_ADDR0;
        end else if (i_in.request_type == ep0r_pkg::REQ_TYPE_OUT
                     && i_in.request_code == ep0r_pkg::REQ_SET_CONFIG) begin
            o_stat.disp_ok = 1'b1;
            o_stat.disp    = ep0r_pkg::S_CONF0;
        end
    end

    // Packet size clamped to the endpoint limit, zero taken as one
    always_comb begin
        if (r_pkt > MaxPkt) begin
            pkt_eff = MaxPkt;
        end else if (r_pkt == 7'd0) begin
            pkt_eff = 7'd1;
        end else begin
            pkt_eff = r_pkt;
        end
        if ({1'b0, r_remain} < pkt_eff) begin
            n_chunk = r_remain;
        end else begin
            n_chunk = pkt_eff[5:0];
        end
    end

    always_comb begin
        case (r_offset)
            6'd0:  dev_byte = 8'(ep0r_pkg::DEVICE_DESC_BYTES);
            6'd1:  dev_byte = 8'h01;
            6'd3:  dev_byte = 8'h02;
            6'd4:  dev_byte = 8'hff;
            6'd6:  dev_byte = 8'hff;
            6'd7:  dev_byte = {1'b0, r_pkt};
            6'd8:  dev_byte = r_vid[7:0];
            6'd9:  dev_byte = r_vid[15:8];
            6'd10: dev_byte = r_pid[7:0];
            6'd11: dev_byte = r_pid[15:8];
            6'd13: dev_byte = 8'h01;
            6'd17: dev_byte = 8'h01;
            default: dev_byte = 8'h00;
        endcase
        if (!r_src_cfg) begin
            rom_byte = dev_byte;
        end else if (r_offset == ep0r_pkg::CFG_TOTAL_SLOT) begin
            rom_byte = {2'b00, CfgTotal};
        end else begin
            rom_byte = ep0r_pkg::cfg_rom(r_offset);
        end
        case (i_uw.lsel)
            ep0r_pkg::LS_ONE: cur_last = 1'b1;
            ep0r_pkg::LS_CNT: cur_last = (r_cnt == 6'd1);
            default:          cur_last = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pkt <= ep0r_pkg::RST_PACKET;
            r_vid <= ep0r_pkg::RST_VENDOR;
            r_pid <= ep0r_pkg::RST_PRODUCT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ep0r_pkg::REG_PACKET:  r_pkt <= i_cfg_data[6:0];
                ep0r_pkg::REG_VENDOR:  r_vid <= i_cfg_data;
                ep0r_pkg::REG_PRODUCT: r_pid <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Hold the request fields that later steps need
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_value_lo <= i_in.request_value[7:0];
            r_len_full <= (i_in.request_length == 16'(CONFIG_TOTAL_BYTES));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_cfg <= 1'b0;
            r_offset  <= 6'd0;
            r_remain  <= 6'd0;
            r_addr    <= 8'd0;
            r_cnt     <= 6'd0;
        end else if (i_go) begin
            case (i_uw.xop)
                ep0r_pkg::XOP_LOAD_DEV: begin
                    r_src_cfg <= 1'b0;
                    r_offset  <= 6'd0;
                    r_remain  <= ep0r_pkg::DEVICE_DESC_BYTES;
                end
                ep0r_pkg::XOP_LOAD_CFG: begin
                    r_src_cfg <= 1'b1;
                    r_offset  <= 6'd0;
                    r_remain  <= r_len_full ? CfgTotal : ep0r_pkg::CONFIG_SHORT_BYTES;
                end
                ep0r_pkg::XOP_CLEAR: begin
                    r_offset <= 6'd0;
                    r_remain <= 6'd0;
                end
                ep0r_pkg::XOP_ADVANCE: begin
                    r_offset <= r_offset + 6'd1;
                    r_remain <= r_remain - 6'd1;
                    r_cnt    <= r_cnt - 6'd1;
                end
                default: ;
            endcase
            if (i_uw.ld_addr) begin
                r_addr <= r_value_lo;
            end
            if (i_uw.ld_cnt) begin
                r_cnt <= n_chunk;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_go && i_uw.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go && i_uw.emit) begin
            r_out.kind           <= i_uw.kind;
            r_out.data_byte      <= (i_uw.kind == ep0r_pkg::KIND_DATA) ? rom_byte : 8'd0;
            r_out.device_address <= (i_uw.kind == ep0r_pkg::KIND_ADDR) ? r_addr : 8'd0;
            r_out.last           <= cur_last;
        end
    end

endmodule

// ----- src/usb_ep0_standard_request_responder.sv -----
// Top level of the endpoint zero standard request responder.
// Input channel (i_in_valid / o_in_ready / i_in) takes one word per request:
// a decoded setup packet or an IN token on endpoint zero. Output channel
// (o_out_valid / i_out_ready / o_out) gives the run of result words it causes:
// descriptor bytes, empty packets, stalls, the assigned address, configured.
// The configuration port writes packet size (index 0), vendor id (1) and
// product id (2); write only while the block is idle.
// A microprogram steps through a small control store, one step per cycle unless stalled.
// o_in_ready is high only on the idle step, so one request is worked at a time.
// After a descriptor request is accepted the sequencer passes S_DEV or S_CFG,
// then S_CHUNK, then S_BYTE, which fills the output register; an IN token
// starts at S_CHUNK. Bytes follow one per cycle while the output register is
// free, and the next word is taken back on the idle step. Address and
// configuration requests give two words.
// Unknown requests and IN tokens before an address is set give no words and
// the block is ready again on the next cycle.
// The output register holds a word while i_out_ready is low; an emitting
// step waits for it, so a stalled receiver stalls the sequencer.
// Reset (synchronous, active low) clears the transfer state and stored
// address, empties the output register and restores the register defaults.
`timescale 1ns / 1ps

module usb_ep0_standard_request_responder #(
    parameter int MAX_PACKET         = 64,
    parameter int CONFIG_TOTAL_BYTES = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  ep0r_pkg::t_in  i_in,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output ep0r_pkg::t_out o_out,
    input  logic           i_cfg_we,
    input  logic [1:0]     i_cfg_idx,
    input  logic [15:0]    i_cfg_data
);

    ep0r_pkg::t_uword uw;
    ep0r_pkg::t_stat  stat;
    logic             go;

    ep0r_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_uw    (uw),
        .o_go    (go)
    );

    ep0r_dp #(
        .MAX_PACKET         (MAX_PACKET),
        .CONFIG_TOTAL_BYTES (CONFIG_TOTAL_BYTES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_uw        (uw),
        .i_go        (go),
        .o_stat      (stat)
    );

endmodule

// ----- src/ep0r_chk.sv -----
// Port-level checker for the endpoint zero responder, bound to the top level.
`timescale 1ns / 1ps

module ep0r_chk (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_ready,
    input ep0r_pkg::t_in  i_in,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input ep0r_pkg::t_out o_out,
    input logic           i_cfg_we,
    input logic [1:0]     i_cfg_idx,
    input logic [15:0]    i_cfg_data
);

    // Hold a stalled result word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result word changed while stalled");

    a_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.kind != ep0r_pkg::KIND_DATA |-> o_out.data_byte == 8'd0)
        else $error("data byte set on a non-data word");

    a_final_kinds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.kind == ep0r_pkg::KIND_ADDR
                        || o_out.kind == ep0r_pkg::KIND_STALL) |-> o_out.last)
        else $error("address or stall word not marked last");

    // An address request keeps the block busy on the following cycle
    a_busy_after_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in.action == ep0r_pkg::ACT_SETUP
        && i_in.request_type == ep0r_pkg::REQ_TYPE_OUT
        && i_in.request_code == ep0r_pkg::REQ_SET_ADDR |=> !o_in_ready)
        else $error("ready again right after an address request");

endmodule

bind usb_ep0_standard_request_responder ep0r_chk u_chk (.*);

// ----- verif/tb.sv -----
// Self-checking testbench for the endpoint zero standard request responder.
`timescale 1ns / 1ps

module tb;

    localparam int DRAIN_CYCLES   = 12;
    localparam int CYCLE_LIMIT    = 500000;
    localparam int MAX_REPORTS    = 10;
    localparam int CFG_FULL_BYTES = 32;
    localparam int IDLE_PERCENT   = 34;

    logic           i_clk    = 1'b0;
    logic           i_rst_n  = 1'b0;
    logic           in_valid = 1'b0;
    logic           in_ready;
    ep0r_pkg::t_in  in_word  = '0;
    logic           out_valid;
    logic           out_ready = 1'b0;
    ep0r_pkg::t_out out_word;
    logic           cfg_we   = 1'b0;
    logic [1:0]     cfg_idx  = ep0r_pkg::REG_PACKET;
    logic [15:0]    cfg_data = '0;

    // Mirror of the block: registers and transfer state
    logic [6:0]  pkt_size     = ep0r_pkg::RST_PACKET;
    logic [15:0] vendor       = ep0r_pkg::RST_VENDOR;
    logic [15:0] product      = ep0r_pkg::RST_PRODUCT;
    logic        from_cfg_rom = 1'b0;
    logic [5:0]  xfer_offset  = '0;
    logic [5:0]  xfer_left    = '0;
    logic [7:0]  dev_addr     = '0;

    ep0r_pkg::t_out reply_q[$];
    ep0r_pkg::t_in  request_q[$];
    ep0r_pkg::t_out want;
    logic calm       = 1'b0;
    int   errors     = 0;
    int   cycles     = 0;
    int   work_items = 0;

    usb_ep0_standard_request_responder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_word),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [7:0] device_desc_byte(input logic [5:0] idx);
        case (idx)
            6'd0:    return 8'd18;
            6'd1:    return 8'h01;
            6'd3:    return 8'h02;
            6'd4:    return 8'hff;
            6'd6:    return 8'hff;
            6'd7:    return {1'b0, pkt_size};
            6'd8:    return vendor[7:0];
            6'd9:    return vendor[15:8];
            6'd10:   return product[7:0];
            6'd11:   return product[15:8];
            6'd13:   return 8'h01;
            6'd17:   return 8'h01;
            default: return 8'h00;
        endcase
    endfunction

    // One configuration, one interface, two bulk endpoints; zero past the end
    function automatic logic [7:0] config_desc_byte(input logic [5:0] idx);
        case (idx)
            6'd0, 6'd9:                 return 8'h09;
            6'd2:                       return CFG_FULL_BYTES[7:0];
            6'd4, 6'd5, 6'd24, 6'd31:   return 8'h01;
            6'd7:                       return 8'h80;
            6'd8:                       return 8'd250;
            6'd10:                      return 8'h04;
            6'd1, 6'd13, 6'd21, 6'd27,
            6'd28:                      return 8'h02;
            6'd14, 6'd16:               return 8'hff;
            6'd18, 6'd25:               return 8'h07;
            6'd19, 6'd26:               return 8'h05;
            6'd20:                      return 8'h82;
            6'd22, 6'd29:               return 8'd64;
            default:                    return 8'h00;
        endcase
    endfunction

    function automatic int packet_limit();
        if (pkt_size > 7'd64) return 64;
        if (pkt_size == 7'd0) return 1;
        return int'(pkt_size);
    endfunction

    function automatic ep0r_pkg::t_out reply(input ep0r_pkg::t_kind k, input logic [7:0] d,
                                             input logic [7:0] a, input logic l);
        ep0r_pkg::t_out r;
        r.kind           = k;
        r.data_byte      = d;
        r.device_address = a;
        r.last           = l;
        return r;
    endfunction

    task automatic queue_packet();
        int         n;
        logic [5:0] idx;
        n = (int'(xfer_left) < packet_limit()) ? int'(xfer_left) : packet_limit();
        if (n == 0) begin
            reply_q.push_back(reply(ep0r_pkg::KIND_EMPTY, 8'h00, 8'h00, 1'b1));
        end else begin
            for (int i = 0; i < n; i++) begin
                idx = xfer_offset + 6'(i);
                reply_q.push_back(reply(ep0r_pkg::KIND_DATA,
                    from_cfg_rom ? config_desc_byte(idx) : device_desc_byte(idx),
                    8'h00, i == n - 1));
            end
            xfer_left   = xfer_left - 6'(n);
            xfer_offset = xfer_offset + 6'(n);
        end
    endtask

    task automatic predict_reply(input ep0r_pkg::t_in w);
        if (w.action == ep0r_pkg::ACT_IN) begin
            // tokens are ignored until an address is stored
            if (dev_addr != 8'h00) queue_packet();
        end else if (w.request_type == ep0r_pkg::REQ_TYPE_IN
                     && w.request_code == ep0r_pkg::REQ_GET_DESC) begin
            case (w.request_value[15:8])
                ep0r_pkg::DESC_DEVICE: begin
                    from_cfg_rom = 1'b0;
                    xfer_offset  = '0;
                    xfer_left    = ep0r_pkg::DEVICE_DESC_BYTES;
                    queue_packet();
                end
                ep0r_pkg::DESC_CONFIG: begin
                    from_cfg_rom = 1'b1;
                    xfer_offset  = '0;
                    xfer_left    = (w.request_length == 16'(CFG_FULL_BYTES))
                                   ? 6'(CFG_FULL_BYTES) : ep0r_pkg::CONFIG_SHORT_BYTES;
                    queue_packet();
                end
                ep0r_pkg::DESC_QUALIFIER:
                    reply_q.push_back(reply(ep0r_pkg::KIND_STALL, 8'h00, 8'h00, 1'b1));
                default: ;
            endcase
        end else if (w.request_type == ep0r_pkg::REQ_TYPE_OUT
                     && w.request_code == ep0r_pkg::REQ_SET_ADDR) begin
            xfer_offset = '0;
            xfer_left   = '0;
            dev_addr    = w.request_value[7:0];
            reply_q.push_back(reply(ep0r_pkg::KIND_EMPTY, 8'h00, 8'h00, 1'b0));
            reply_q.push_back(reply(ep0r_pkg::KIND_ADDR, 8'h00, dev_addr, 1'b1));
        end else if (w.request_type == ep0r_pkg::REQ_TYPE_OUT
                     && w.request_code == ep0r_pkg::REQ_SET_CONFIG) begin
            xfer_offset = '0;
            xfer_left   = '0;
            reply_q.push_back(reply(ep0r_pkg::KIND_CONFIGURED, 8'h00, 8'h00, 1'b0));
            reply_q.push_back(reply(ep0r_pkg::KIND_EMPTY, 8'h00, 8'h00, 1'b1));
        end
    endtask

    // Driver: hold the word until accepted, then advance or idle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_ready) begin
            if (in_valid) predict_reply(in_word);
            if (request_q.size() > 0 && (calm || $urandom_range(99) >= IDLE_PERCENT)) begin
                in_valid <= 1'b1;
                in_word  <= request_q.pop_front();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        out_ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
    end

    // Monitor
    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && out_ready) begin
            if (reply_q.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("unexpected word: kind %0d data %h addr %h last %b",
                             out_word.kind, out_word.data_byte, out_word.device_address,
                             out_word.last);
            end else begin
                want = reply_q.pop_front();
                if (out_word.kind !== want.kind || out_word.data_byte !== want.data_byte ||
                    out_word.device_address !== want.device_address ||
                    out_word.last !== want.last) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("mismatch: exp %0d %h %h %b, got %0d %h %h %b",
                                 want.kind, want.data_byte, want.device_address, want.last,
                                 out_word.kind, out_word.data_byte, out_word.device_address,
                                 out_word.last);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic ep0r_pkg::t_in setup_word(input logic [7:0] rt, input logic [7:0] rc,
                                                 input logic [15:0] val,
                                                 input logic [15:0] len);
        ep0r_pkg::t_in w;
        w.action         = ep0r_pkg::ACT_SETUP;
        w.request_type   = rt;
        w.request_code   = rc;
        w.request_value  = val;
        w.request_length = len;
        return w;
    endfunction

    // IN token with junk in the setup fields
    function automatic ep0r_pkg::t_in token_word();
        ep0r_pkg::t_in w;
        w        = ep0r_pkg::t_in'({$urandom, $urandom});
        w.action = ep0r_pkg::ACT_IN;
        return w;
    endfunction

    task automatic add_tokens(input int n);
        for (int i = 0; i < n; i++) begin
            request_q.push_back(token_word());
            work_items++;
        end
    endtask

    task automatic add_random_sequence();
        int            pick;
        int            total;
        logic [15:0]   val;
        logic [15:0]   len;
        ep0r_pkg::t_in w;
        pick = $urandom_range(99);
        val  = 16'($urandom);
        len  = 16'($urandom);
        if (pick < 15) begin
            if ($urandom_range(9) == 0) val[7:0] = 8'h00;
            request_q.push_back(setup_word(ep0r_pkg::REQ_TYPE_OUT, ep0r_pkg::REQ_SET_ADDR,
                                           val, len));
            work_items++;
            add_tokens($urandom_range(0, 2));
        end else if (pick < 70) begin
            if (pick < 45) begin
                val[15:8] = ep0r_pkg::DESC_DEVICE;
                total     = 18;
            end else begin
                val[15:8] = ep0r_pkg::DESC_CONFIG;
                case ($urandom_range(3))
                    0, 1: len = 16'(CFG_FULL_BYTES);
                    2:    len = 16'($urandom_range(0, 40));
                    default: ;
                endcase
                total = (len == 16'(CFG_FULL_BYTES)) ? CFG_FULL_BYTES : 9;
            end
            request_q.push_back(setup_word(ep0r_pkg::REQ_TYPE_IN, ep0r_pkg::REQ_GET_DESC,
                                           val, len));
            work_items++;
            // drain the transfer, sometimes stop short or run past the end
            add_tokens((total + packet_limit() - 1) / packet_limit() - 1 + $urandom_range(0, 2)
                       - ($urandom_range(5) == 0 ? 1 : 0));
        end else if (pick < 78) begin
            val[15:8] = ep0r_pkg::DESC_QUALIFIER;
            request_q.push_back(setup_word(ep0r_pkg::REQ_TYPE_IN, ep0r_pkg::REQ_GET_DESC,
                                           val, len));
            work_items++;
        end else if (pick < 86) begin
            request_q.push_back(setup_word(ep0r_pkg::REQ_TYPE_OUT, ep0r_pkg::REQ_SET_CONFIG,
                                           val, len));
            work_items++;
        end else begin
            case ($urandom_range(2))
                0: w = ep0r_pkg::t_in'({$urandom, $urandom});
                1: w = setup_word(ep0r_pkg::REQ_TYPE_IN, ep0r_pkg::REQ_GET_DESC, val, len);
                default: w = ($urandom_range(1) == 0)
                    ? setup_word(ep0r_pkg::REQ_TYPE_OUT, ep0r_pkg::REQ_GET_DESC, val, len)
                    : setup_word(ep0r_pkg::REQ_TYPE_IN, ep0r_pkg::REQ_SET_ADDR, val, len);
            endcase
            request_q.push_back(w);
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            ep0r_pkg::REG_PACKET:  pkt_size = val[6:0];
            ep0r_pkg::REG_VENDOR:  vendor   = val;
            ep0r_pkg::REG_PRODUCT: product  = val;
            default: ;
        endcase
    endtask

    task automatic settle();
        @(posedge i_clk);
        while (request_q.size() != 0 || in_valid || reply_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_phase(input logic [6:0] p, input logic [15:0] v, input logic [15:0] d,
                             input int target);
        settle();
        write_reg(ep0r_pkg::REG_PACKET, {9'd0, p});
        write_reg(ep0r_pkg::REG_VENDOR, v);
        write_reg(ep0r_pkg::REG_PRODUCT, d);
        work_items = 0;
        request_q.push_back(setup_word(ep0r_pkg::REQ_TYPE_OUT, ep0r_pkg::REQ_SET_ADDR,
                                       {8'($urandom), 8'($urandom_range(1, 255))}, 16'h0000));
        while (work_items < target) add_random_sequence();
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Default registers: token before an address, device descriptors, stall, unknown requests,
        // address zero, full and short configuration transfers, set configuration
        request_q.push_back(token_word());
        request_q.push_back(setup_word(ep0r_pkg::REQ_TYPE_IN, ep0r_pkg::REQ_GET_DESC,
                                       16'h0100, 16'hffff));
        request_q.push_back(setup_word(ep0r_pkg::REQ_TYPE_IN, ep0r_pkg::REQ_GET_DESC,
                                       16'h0600, 16'h000a));
        request_q.push_back(setup_word(ep0r_pkg::REQ_TYPE_IN, ep0r_pkg::REQ_GET_DESC,
                                       16'h0300, 16'h00ff));
        request_q.push_back(setup_word(8'hff, 8'hff, 16'hffff, 16'hffff));
        request_q.push_back(setup_word(ep0r_pkg::REQ_TYPE_IN, ep0r_pkg::REQ_SET_ADDR,
                                       16'h0011, 16'h0000));
        request_q.push_back(setup_word(ep0r_pkg::REQ_TYPE_OUT, ep0r_pkg::REQ_SET_ADDR,
                                       16'h0000, 16'h0000));
        request_q.push_back(token_word());
        request_q.push_back(setup_word(ep0r_pkg::REQ_TYPE_OUT, ep0r_pkg::REQ_SET_ADDR,
                                       16'hff7f, 16'hffff));
        request_q.push_back(token_word());
        request_q.push_back(setup_word(ep0r_pkg::REQ_TYPE_IN, ep0r_pkg::REQ_GET_DESC,
                                       16'h0100, 16'h0012));
        repeat (3) request_q.push_back(token_word());
        request_q.push_back(setup_word(ep0r_pkg::REQ_TYPE_IN, ep0r_pkg::REQ_GET_DESC,
                                       16'h0200, 16'h0020));
        repeat (4) request_q.push_back(token_word());
        request_q.push_back(setup_word(ep0r_pkg::REQ_TYPE_IN, ep0r_pkg::REQ_GET_DESC,
                                       16'h02ff, 16'h0009));
        request_q.push_back(token_word());
        request_q.push_back(setup_word(ep0r_pkg::REQ_TYPE_OUT, ep0r_pkg::REQ_SET_CONFIG,
                                       16'h0001, 16'h0000));
        request_q.push_back(setup_word(ep0r_pkg::REQ_TYPE_OUT, ep0r_pkg::REQ_SET_ADDR,
                                       16'h0080, 16'h0000));
        request_q.push_back(token_word());

        run_phase(7'd1, 16'h0000, 16'hffff, 18);
        run_phase(7'd64, 16'hffff, 16'h0000, 18);
        run_phase(7'd0, 16'($urandom), 16'($urandom), 18);
        run_phase(7'd127, 16'($urandom), 16'($urandom), 18);
        calm = 1'b1;
        run_phase(ep0r_pkg::RST_PACKET, ep0r_pkg::RST_VENDOR, ep0r_pkg::RST_PRODUCT, 18);
        settle();
        calm = 1'b0;
        run_phase(7'($urandom_range(1, 64)), 16'($urandom), 16'($urandom), 18);
        run_phase(7'($urandom_range(2, 20)), 16'($urandom), 16'($urandom), 18);
        settle();

        errors += reply_q.size();
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
